FILE: hdl/bcnam_pkg.sv
// Shared types, codes and helpers of the block cache node age manager.
// No dependencies; every other file imports this package.
package bcnam_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int KEEP_W         = 16;
    localparam logic [15:0] AGE_GUARD    = 16'd3;
    localparam logic [15:0] RESIDENT_MIN = 16'd5;
    localparam logic [15:0] AGE_MAX      = 16'hFFFF;
    localparam logic [15:0] REFS_MAX     = 16'hFFFF;

    // opcodes
    localparam logic [1:0] OP_REF     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SWEEP   = 2'd2;

    localparam logic [1:0] MODE_PEEK = 2'd0;

    // result status codes
    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_PEEK    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_BLOCK_LOG2 = 2'd0;
    localparam logic [1:0] CFG_MEM_BYTES  = 2'd1;
    localparam logic [1:0] CFG_SLOW       = 2'd2;
    localparam logic [1:0] CFG_SRC_LEN    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sample_offset;
        logic [1:0]  load_mode;
        logic [15:0] sweep_keep;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic [31:0] block_base;
        logic [15:0] block_refs;
        logic [6:0]  freed_count;
        logic [6:0]  block_count;
        logic [6:0]  idle_count;
    } t_res;

    typedef struct packed {
        logic [31:0] base;
        logic [15:0] refs;
        logic [15:0] age;
    } t_entry;

    // budget decision handed to the sequencer
    typedef struct packed {
        logic              need;
        logic [KEEP_W-1:0] keep;
    } t_bud;

    // clamp block size log2 to 4..22
    function automatic logic [4:0] clamp_log2(input logic [4:0] b);
        logic [4:0] r;
        r = b;
        if (r < 5'd4) r = 5'd4;
        if (r > 5'd22) r = 5'd22;
        return r;
    endfunction

endpackage

FILE: hdl/bcnam_budget.sv
// Memory budget check: decides whether idle blocks overrun the byte budget
// and how many recent ages a sweep keeps. Depends on bcnam_pkg.
module bcnam_budget #(
    parameter int CW = 7
) (
    input  logic              i_clk,
    input  logic [4:0]        i_log2,
    input  logic [31:0]       i_cap,
    input  logic              i_slow,
    input  logic [CW-1:0]     i_idle,
    input  logic [CW-1:0]     i_total,
    output bcnam_pkg::t_bud   o_bud
);
    import bcnam_pkg::*;

    localparam int MW = (CW + 22 > 33) ? CW + 23 : 34;

    logic [MW-1:0] mem_b, cap_w, over_b, n_w, keep_w, half;
    bcnam_pkg::t_bud n_bud;

    // compare idle bytes against budget and derive keep count
    always_comb begin
        mem_b  = MW'(i_idle) << i_log2;
        cap_w  = MW'(i_cap);
        n_w    = MW'(i_total);
        half   = n_w >> 1;
        over_b = (mem_b - cap_w + (cap_w >> 4)) >> i_log2;
        if (over_b > n_w) over_b = n_w;
        if (i_slow) begin
            keep_w = half + (half >> 1);
            if (keep_w < n_w - over_b) keep_w = n_w - over_b;
        end else begin
            keep_w = n_w >> 2;
        end
        if (keep_w < MW'(RESIDENT_MIN)) keep_w = MW'(RESIDENT_MIN);
        n_bud.need = (mem_b > cap_w);
        n_bud.keep = keep_w[KEEP_W-1:0];
    end

    // register the decision
    always_ff @(posedge i_clk) begin
        o_bud <= n_bud;
    end

endmodule

FILE: hdl/block_cache_node_age_manager.sv
// Top level of the block cache node age manager: sequencer and entry memory.
// Depends on bcnam_pkg and bcnam_budget.
//
// Usage: pulse start with a request on i_req while busy is low; the request
// is taken at that edge and busy rises. When done, o_valid is high for one
// cycle with the result on o_res; the receiver cannot stall, so the result
// must be taken in that cycle. busy falls after that cycle.
// Configuration: i_cfg_we with i_cfg_idx / i_cfg_data writes a register at
// once; write only while busy is low.
// Sequence: an offset out of range goes straight to the result; a lookup is
// a bisection, each probe a read (S_SRCH) and a compare (S_CMP). An insert
// then shifts each later entry by a read and a write back through the single
// entry memory port pair. A sweep compacts the table, reading and writing
// back each entry; a release that leaves a block idle runs the budget check
// (S_BWAIT, S_BUSE) and sweeps if it is overrun. One request at a time.
// Reset: counters and the newest age clear, registers take their defaults;
// the entry memory is not cleared, only entries below the count are read.
module block_cache_node_age_manager #(
    parameter int MAX_BLOCKS = bcnam_pkg::MAX_BLOCKS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bcnam_pkg::t_req i_req,
    output logic            o_valid,
    output bcnam_pkg::t_res o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);
    import bcnam_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_HIT   = 4'd3;
    localparam logic [3:0] S_MISS  = 4'd4;
    localparam logic [3:0] S_SHRD  = 4'd5;
    localparam logic [3:0] S_SHWR  = 4'd6;
    localparam logic [3:0] S_BWAIT = 4'd7;
    localparam logic [3:0] S_BUSE  = 4'd8;
    localparam logic [3:0] S_SWI   = 4'd9;
    localparam logic [3:0] S_SWRD  = 4'd10;
    localparam logic [3:0] S_SWWR  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // configuration
    logic [4:0]  r_cfg_log2;
    logic [31:0] r_cfg_mem;
    logic        r_cfg_slow;
    logic [31:0] r_cfg_len;

    // control state
    logic [3:0]        r_state;
    logic [CW-1:0]     r_total, r_idle;
    logic [15:0]       r_newest;
    t_req              r_req;
    logic [CW-1:0]     r_lo, r_n, r_si, r_ri, r_w, r_freed, r_slot;
    logic [IW-1:0]     r_c;
    logic              r_cvld;
    logic [31:0]       r_cbase;
    t_entry            r_cent;
    logic [KEEP_W-1:0] r_keep;
    logic [15:0]       r_rej;
    logic [2:0]        r_status;
    logic [31:0]       r_base;
    logic [15:0]       r_refs;

    // entry memory
    t_entry            r_mem [MAX_BLOCKS];
    t_entry            r_rdata;
    logic              rd_en, wr_en;
    logic [IW-1:0]     rd_addr, wr_addr;
    t_entry            wr_data;

    t_bud              bud;
    logic [4:0]        lg;
    logic [32:0]       bs, off33, hi33;
    logic [31:0]       aligned;
    logic [CW:0]       half_i;
    logic [CW-1:0]     c_full, pos;
    logic [16:0]       age_g;
    logic [15:0]       nn_age;
    logic [KEEP_W-1:0] keep_c;
    logic [KEEP_W-1:0] newest_k;
    logic [15:0]       age_sub;
    logic [31:0]       slot_w, freed_w, total_w, idle_w;

    assign lg      = clamp_log2(r_cfg_log2);
    assign bs      = 33'd1 << (lg - 5'd2);
    assign aligned = r_req.sample_offset & ~(bs[31:0] - 32'd1);
    assign off33   = {1'b0, r_req.sample_offset};
    assign hi33    = {1'b0, r_rdata.base} + bs;
    assign half_i  = ({1'b0, r_n} + (CW+1)'(1)) >> 1;
    assign c_full  = r_lo + half_i[CW-1:0] - CW'(1);
    assign pos     = r_cvld ? (CW'(r_c) + CW'(r_req.sample_offset > r_cbase)) : '0;
    assign age_g   = {1'b0, r_cent.age} + 17'(AGE_GUARD);
    assign nn_age  = (r_newest < AGE_MAX) ? r_newest + 16'd1 : r_newest;
    assign keep_c  = (r_keep < KEEP_W'(AGE_GUARD)) ? KEEP_W'(AGE_GUARD) : r_keep;
    assign newest_k = KEEP_W'(r_newest);
    assign age_sub = (r_rej < r_rdata.age) ? r_rej : r_rdata.age;

    bcnam_budget #(.CW(CW)) u_budget (
        .i_clk   (i_clk),
        .i_log2  (lg),
        .i_cap   (r_cfg_mem),
        .i_slow  (r_cfg_slow),
        .i_idle  (r_idle),
        .i_total (r_total),
        .o_bud   (bud)
    );

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_cent;
        case (r_state)
            S_SRCH: begin
                rd_en   = (r_n != '0);
                rd_addr = c_full[IW-1:0];
            end
            S_SHRD: begin
                rd_en   = (r_si != pos);
                rd_addr = IW'(r_si - CW'(1));
                if (r_si == pos) begin
                    wr_en   = 1'b1;
                    wr_addr = pos[IW-1:0];
                    wr_data = '{base: aligned, refs: 16'd1, age: 16'd0};
                end
            end
            S_SHWR: begin
                wr_en   = 1'b1;
                wr_addr = r_si[IW-1:0];
                wr_data = r_rdata;
            end
            S_HIT: begin
                wr_addr = r_c;
                if (r_req.opcode == OP_REF) begin
                    wr_en   = (r_cent.refs != REFS_MAX);
                    wr_data = '{base: r_cent.base, refs: r_cent.refs + 16'd1, age: r_cent.age};
                end else if (r_cent.base == r_req.sample_offset && r_cent.refs != '0) begin
                    wr_en   = 1'b1;
                    wr_data = r_cent;
                    wr_data.refs = r_cent.refs - 16'd1;
                    if (r_cent.refs == 16'd1 &&
                        (age_g <= {1'b0, r_newest} || r_newest < AGE_GUARD)) begin
                        wr_data.age = nn_age;
                    end
                end
            end
            S_SWRD: begin
                rd_en   = (r_ri != r_total);
                rd_addr = r_ri[IW-1:0];
            end
            S_SWWR: begin
                wr_en   = !(r_rdata.refs == '0 && r_rdata.age <= r_rej);
                wr_addr = r_w[IW-1:0];
                wr_data = '{base: r_rdata.base, refs: r_rdata.refs,
                            age: r_rdata.age - age_sub};
            end
            default: begin
            end
        endcase
    end

    // synchronous entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // payload holding registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        if (r_state == S_CMP) begin
            r_cbase <= r_rdata.base;
            r_cent  <= r_rdata;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_log2 <= 5'd14;
            r_cfg_mem  <= 32'd16777216;
            r_cfg_slow <= 1'b0;
            r_cfg_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_LOG2: r_cfg_log2 <= i_cfg_data[4:0];
                CFG_MEM_BYTES:  r_cfg_mem  <= i_cfg_data;
                CFG_SLOW:       r_cfg_slow <= i_cfg_data[0];
                CFG_SRC_LEN:    r_cfg_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_idle   <= '0;
            r_newest <= '0;
            r_lo     <= '0;
            r_n      <= '0;
            r_c      <= '0;
            r_cvld   <= 1'b0;
            r_si     <= '0;
            r_ri     <= '0;
            r_w      <= '0;
            r_freed  <= '0;
            r_slot   <= '0;
            r_keep   <= '0;
            r_rej    <= '0;
            r_status <= ST_HIT;
            r_base   <= '0;
            r_refs   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_status <= ST_HIT;
                        r_slot   <= '0;
                        r_base   <= '0;
                        r_refs   <= '0;
                        r_freed  <= '0;
                        r_lo     <= '0;
                        r_n      <= r_total;
                        r_cvld   <= 1'b0;
                        r_keep   <= i_req.sweep_keep;
                        if (i_req.opcode == OP_REF) begin
                            if (i_req.sample_offset >= r_cfg_len) begin
                                r_status <= ST_RANGE;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_SRCH;
                            end
                        end else if (i_req.opcode == OP_RELEASE) begin
                            r_state <= S_SRCH;
                        end else if (i_req.opcode == OP_SWEEP) begin
                            r_state <= S_SWI;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                // issue the probe read, or go to the miss state when the range is empty
                S_SRCH: begin
                    if (r_n == '0) begin
                        r_state <= S_MISS;
                    end else begin
                        r_c     <= c_full[IW-1:0];
                        r_cvld  <= 1'b1;
                        r_state <= S_CMP;
                    end
                end
                // compare probe against the offset and narrow the range
                S_CMP: begin
                    if (off33 < {1'b0, r_rdata.base}) begin
                        r_n     <= half_i[CW-1:0] - CW'(1);
                        r_state <= S_SRCH;
                    end else if (off33 >= hi33) begin
                        r_n     <= r_n - half_i[CW-1:0];
                        r_lo    <= CW'(r_c) + CW'(1);
                        r_state <= S_SRCH;
                    end else begin
                        r_state <= S_HIT;
                    end
                end
                S_MISS: begin
                    if (r_req.opcode == OP_RELEASE) begin
                        r_status <= ST_UNKNOWN;
                        r_state  <= S_OUT;
                    end else begin
                        r_slot <= pos;
                        r_base <= aligned;
                        if (r_req.load_mode == MODE_PEEK) begin
                            r_status <= ST_PEEK;
                            r_state  <= S_OUT;
                        end else if (r_total >= CW'(MAX_BLOCKS)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_si    <= r_total;
                            r_state <= S_SHRD;
                        end
                    end
                end
                // shift later entries up by one, then place the new entry
                S_SHRD: begin
                    if (r_si == pos) begin
                        r_total  <= r_total + CW'(1);
                        r_refs   <= 16'd1;
                        r_status <= ST_CREATED;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_si    <= r_si - CW'(1);
                    r_state <= S_SHRD;
                end
                S_HIT: begin
                    if (r_req.opcode == OP_REF) begin
                        r_slot <= CW'(r_c);
                        r_base <= r_cent.base;
                        if (r_cent.refs == REFS_MAX) begin
                            r_status <= ST_FULL;
                            r_refs   <= r_cent.refs;
                        end else begin
                            if (r_cent.refs == '0 && r_idle != '0) begin
                                r_idle <= r_idle - CW'(1);
                            end
                            r_refs <= r_cent.refs + 16'd1;
                        end
                        r_state <= S_OUT;
                    end else if (r_cent.base != r_req.sample_offset || r_cent.refs == '0) begin
                        r_status <= ST_UNKNOWN;
                        r_state  <= S_OUT;
                    end else begin
                        r_slot <= CW'(r_c);
                        r_base <= r_cent.base;
                        r_refs <= r_cent.refs - 16'd1;
                        if (r_cent.refs == 16'd1) begin
                            if (age_g <= {1'b0, r_newest} || r_newest < AGE_GUARD) begin
                                r_newest <= nn_age;
                            end
                            r_idle  <= r_idle + CW'(1);
                            r_state <= S_BWAIT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                // let the budget check see the updated counts
                S_BWAIT: begin
                    r_state <= S_BUSE;
                end
                S_BUSE: begin
                    r_keep  <= bud.keep;
                    r_state <= bud.need ? S_SWI : S_OUT;
                end
                S_SWI: begin
                    if (keep_c >= newest_k) begin
                        r_state <= S_OUT;
                    end else begin
                        r_rej    <= r_newest - keep_c[15:0];
                        r_newest <= keep_c[15:0];
                        r_ri     <= '0;
                        r_w      <= '0;
                        r_state  <= S_SWRD;
                    end
                end
                // compact the table, dropping old idle entries
                S_SWRD: begin
                    if (r_ri == r_total) begin
                        r_total <= r_w;
                        r_idle  <= (r_freed <= r_idle) ? r_idle - r_freed : '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SWWR;
                    end
                end
                S_SWWR: begin
                    if (r_rdata.refs == '0 && r_rdata.age <= r_rej) begin
                        r_freed <= r_freed + CW'(1);
                    end else begin
                        r_w <= r_w + CW'(1);
                    end
                    r_ri    <= r_ri + CW'(1);
                    r_state <= S_SWRD;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // drive the result transfer
    assign slot_w  = 32'(r_slot);
    assign freed_w = 32'(r_freed);
    assign total_w = 32'(r_total);
    assign idle_w  = 32'(r_idle);

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    always_comb begin
        o_res.status      = r_status;
        o_res.slot_index  = slot_w[5:0];
        o_res.block_base  = r_base;
        o_res.block_refs  = r_refs;
        o_res.freed_count = freed_w[6:0];
        o_res.block_count = total_w[6:0];
        o_res.idle_count  = idle_w[6:0];
    end

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result transfer outside a request");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request transfer not taken");
    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_BLOCKS)) else $error("entry count above table size");
`endif

endmodule
